/* rtl/lapt_pkg.sv */
// Shared constants, codes and control/status types of the load activity power timeout block.
`timescale 1ns / 1ps
`default_nettype none

package lapt_pkg;

    // Round geometry
    localparam int SAMPLES_PER_PACKET = 16;
    localparam int PACKETS_PER_ROUND  = 3;
    localparam int IDX_W              = 5;
    localparam int PKT_W              = 2;

    // Field and register widths
    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 31;
    localparam int THR_W   = 31;
    localparam int HOLD_W  = 16;
    localparam int TICK_W  = 28;
    localparam int CIDX_W  = 3;

    // Gram conversion: (reading + offset) * 10000 / gain
    localparam int GRAM_SCALE = 10000;
    localparam int SUM_W      = DATA_W + 1;
    localparam int PROD_W     = 47;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    // Hold timer: seconds times 2048 ticks
    localparam int TICK_SHIFT = 11;

    // Register indexes of the configuration port
    localparam logic [CIDX_W-1:0] CFG_ZERO_OFFSET        = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GAIN_DIVISOR       = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_ACTIVITY_THRESHOLD = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_ALLOUT_THRESHOLD   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_HOLD_SECONDS       = 3'd4;

    // Input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic mul_load;
        logic mul_sel_low;
        logic div_start;
        logic grab_high;
        logic grab_low;
        logic decide;
        logic out_load;
    } lapt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic round_close;
        logic div_done;
    } lapt_status_t;

endpackage : lapt_pkg

`default_nettype wire

/* rtl/lapt_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lapt_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lapt_pkg::PROD_W-1:0]   dividend,
    input  wire logic [lapt_pkg::GAIN_W-1:0]   divisor,
    output logic                               done,
    output logic [lapt_pkg::PROD_W-1:0]        quotient
);
    import lapt_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [GAIN_W-1:0]   rem_reg, rem_next;
    logic [GAIN_W-1:0]   dvs_reg, dvs_next;
    logic [GAIN_W:0]     rem_sh;
    logic                fits;

    // One shift-subtract step
    always_comb
    begin
        rem_sh    = {rem_reg, acc_reg[PROD_W-1]};
        fits      = (rem_sh >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_STEPS - 1);
            acc_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? GAIN_W'(rem_sh - {1'b0, dvs_reg}) : GAIN_W'(rem_sh);
            acc_next = {acc_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule : lapt_div

`default_nettype wire

/* rtl/lapt_ctrl.sv */
// Controller state machine sequencing item steps, gram conversion and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module lapt_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    input  wire lapt_pkg::lapt_status_t  status,
    output lapt_pkg::lapt_cmd_t          cmd
);
    import lapt_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_STEP     = 10'b00_0000_0010,
        S_MUL_HI   = 10'b00_0000_0100,
        S_START_HI = 10'b00_0000_1000,
        S_WAIT_HI  = 10'b00_0001_0000,
        S_MUL_LO   = 10'b00_0010_0000,
        S_START_LO = 10'b00_0100_0000,
        S_WAIT_LO  = 10'b00_1000_0000,
        S_DECIDE   = 10'b01_0000_0000,
        S_EMIT     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = status.round_close ? S_MUL_HI : S_EMIT;
            end
            S_MUL_HI:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_START_HI;
            end
            S_START_HI:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_HI;
            end
            S_WAIT_HI:
            begin
                if (status.div_done)
                begin
                    cmd.grab_high = 1'b1;
                    state_next    = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_load    = 1'b1;
                cmd.mul_sel_low = 1'b1;
                state_next      = S_START_LO;
            end
            S_START_LO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_LO;
            end
            S_WAIT_LO:
            begin
                if (status.div_done)
                begin
                    cmd.grab_low = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // result register free, or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule : lapt_ctrl

`default_nettype wire

/* rtl/lapt_dp.sv */
// Datapath: configuration registers, round extremes, gram conversion, power timer, result register.
`timescale 1ns / 1ps
`default_nettype none

module lapt_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [lapt_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [lapt_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                           command,
    input  wire logic signed [lapt_pkg::DATA_W-1:0] sample,
    input  wire lapt_pkg::lapt_cmd_t            cmd,
    output lapt_pkg::lapt_status_t              status,
    output logic                                power_on,
    output logic                                round_done,
    output logic                                activity_seen,
    output logic signed [lapt_pkg::DATA_W-1:0]  high_grams,
    output logic signed [lapt_pkg::DATA_W-1:0]  low_grams
);
    import lapt_pkg::*;

    // Configuration registers
    logic signed [DATA_W-1:0] zero_offset_reg;
    logic [GAIN_W-1:0]        gain_divisor_reg;
    logic [THR_W-1:0]         activity_threshold_reg;
    logic signed [DATA_W-1:0] allout_threshold_reg;
    logic [HOLD_W-1:0]        hold_seconds_reg;

    // Block state
    logic signed [DATA_W-1:0] round_high_reg, round_high_next;
    logic signed [DATA_W-1:0] round_low_reg, round_low_next;
    logic [IDX_W-1:0]         sample_index_reg, sample_index_next;
    logic [PKT_W-1:0]         packet_count_reg, packet_count_next;
    logic [TICK_W-1:0]        ticks_left_reg, ticks_left_next;
    logic                     power_flag_reg, power_flag_next;

    // Captured item and working values
    logic                     item_cmd_reg;
    logic signed [DATA_W-1:0] item_sample_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] hg_reg, hg_next;
    logic signed [DATA_W-1:0] lg_reg, lg_next;
    logic                     done_reg, done_next;
    logic                     active_reg, active_next;

    // Result register
    logic                     power_on_reg;
    logic                     round_done_reg;
    logic                     activity_seen_reg;
    logic signed [DATA_W-1:0] high_grams_reg;
    logic signed [DATA_W-1:0] low_grams_reg;

    logic [IDX_W-1:0]         idx_inc;
    logic [PKT_W-1:0]         pkt_inc;
    logic                     packet_end;
    logic                     round_close;
    logic signed [DATA_W-1:0] conv_in;
    logic signed [SUM_W-1:0]  conv_sum;
    logic signed [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0]        prod_mag;
    logic [GAIN_W-1:0]        div_eff;
    logic                     div_done;
    logic [PROD_W-1:0]        div_quot;
    logic [DATA_W-1:0]        gram_val;
    logic signed [SUM_W-1:0]  spread;
    logic                     trigger;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg        <= '0;
            gain_divisor_reg       <= GAIN_W'(1);
            activity_threshold_reg <= THR_W'(800);
            allout_threshold_reg   <= DATA_W'(10000);
            hold_seconds_reg       <= HOLD_W'(300);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ZERO_OFFSET:        zero_offset_reg        <= cfg_data;
                CFG_GAIN_DIVISOR:       gain_divisor_reg       <= cfg_data[GAIN_W-1:0];
                CFG_ACTIVITY_THRESHOLD: activity_threshold_reg <= cfg_data[THR_W-1:0];
                CFG_ALLOUT_THRESHOLD:   allout_threshold_reg   <= cfg_data;
                CFG_HOLD_SECONDS:       hold_seconds_reg       <= cfg_data[HOLD_W-1:0];
                default:                ;
            endcase
        end
    end

    // Packet and round position
    assign idx_inc     = IDX_W'(sample_index_reg + 1'b1);
    assign pkt_inc     = PKT_W'(packet_count_reg + 1'b1);
    assign packet_end  = (idx_inc >= IDX_W'(SAMPLES_PER_PACKET));
    assign round_close = (item_cmd_reg == CMD_SAMPLE) && packet_end
                         && (pkt_inc >= PKT_W'(PACKETS_PER_ROUND));

    // Offset, scale and sign split ahead of the divider
    assign conv_in   = cmd.mul_sel_low ? round_low_reg : round_high_reg;
    assign conv_sum  = {conv_in[DATA_W-1], conv_in}
                       + {zero_offset_reg[DATA_W-1], zero_offset_reg};
    assign prod_next = $signed({{(PROD_W-SUM_W){conv_sum[SUM_W-1]}}, conv_sum})
                       * $signed(PROD_W'(GRAM_SCALE));
    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(~prod_reg + 1'b1) : prod_reg;
    assign div_eff   = (gain_divisor_reg == '0) ? GAIN_W'(1) : gain_divisor_reg;

    lapt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_mag),
        .divisor  (div_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Restore the sign on the low 32 bits of the quotient
    assign gram_val = neg_reg ? DATA_W'(~div_quot[DATA_W-1:0] + 1'b1) : div_quot[DATA_W-1:0];

    // Round evaluation
    assign spread  = {hg_reg[DATA_W-1], hg_reg} - {lg_reg[DATA_W-1], lg_reg};
    assign trigger = (spread > $signed({2'b00, activity_threshold_reg}))
                     || (hg_reg > allout_threshold_reg);

    // State updates
    always_comb
    begin
        round_high_next   = round_high_reg;
        round_low_next    = round_low_reg;
        sample_index_next = sample_index_reg;
        packet_count_next = packet_count_reg;
        ticks_left_next   = ticks_left_reg;
        power_flag_next   = power_flag_reg;
        hg_next           = hg_reg;
        lg_next           = lg_reg;
        done_next         = done_reg;
        active_next       = active_reg;
        if (cmd.step)
        begin
            hg_next     = '0;
            lg_next     = '0;
            done_next   = 1'b0;
            active_next = 1'b0;
            if (item_cmd_reg == CMD_TICK)
            begin
                if (ticks_left_reg != '0)
                    ticks_left_next = ticks_left_reg - 1'b1;
            end
            else
            begin
                if (item_sample_reg > round_high_reg)
                    round_high_next = item_sample_reg;
                if (item_sample_reg < round_low_reg)
                    round_low_next = item_sample_reg;
                sample_index_next = idx_inc;
                if (packet_end)
                begin
                    sample_index_next = '0;
                    packet_count_next = round_close ? '0 : pkt_inc;
                end
            end
        end
        if (cmd.grab_high)
            hg_next = gram_val;
        if (cmd.grab_low)
            lg_next = gram_val;
        if (cmd.decide)
        begin
            done_next   = 1'b1;
            active_next = trigger;
            if (trigger)
            begin
                power_flag_next = 1'b1;
                ticks_left_next = TICK_W'({hold_seconds_reg, {TICK_SHIFT{1'b0}}}) + 1'b1;
            end
            else if (ticks_left_reg == '0)
            begin
                power_flag_next = 1'b0;
            end
            round_high_next = {1'b1, {(DATA_W-1){1'b0}}};
            round_low_next  = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_high_reg   <= {1'b1, {(DATA_W-1){1'b0}}};
            round_low_reg    <= {1'b0, {(DATA_W-1){1'b1}}};
            sample_index_reg <= '0;
            packet_count_reg <= '0;
            ticks_left_reg   <= '0;
            power_flag_reg   <= 1'b0;
        end
        else
        begin
            round_high_reg   <= round_high_next;
            round_low_reg    <= round_low_next;
            sample_index_reg <= sample_index_next;
            packet_count_reg <= packet_count_next;
            ticks_left_reg   <= ticks_left_next;
            power_flag_reg   <= power_flag_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_cmd_reg    <= command;
            item_sample_reg <= sample;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= prod_next;
            neg_reg  <= prod_next[PROD_W-1];
        end
        hg_reg     <= hg_next;
        lg_reg     <= lg_next;
        done_reg   <= done_next;
        active_reg <= active_next;
        if (cmd.out_load)
        begin
            power_on_reg      <= power_flag_reg;
            round_done_reg    <= done_reg;
            activity_seen_reg <= active_reg;
            high_grams_reg    <= hg_reg;
            low_grams_reg     <= lg_reg;
        end
    end

    assign status.round_close = round_close;
    assign status.div_done    = div_done;

    assign power_on      = power_on_reg;
    assign round_done    = round_done_reg;
    assign activity_seen = activity_seen_reg;
    assign high_grams    = high_grams_reg;
    assign low_grams     = low_grams_reg;

endmodule : lapt_dp

`default_nettype wire

/* rtl/load_activity_power_timeout.sv */
// Top level of the load activity power timeout block: controller plus datapath.
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   in
//  in       in_valid/in_ready, command, sample         in
//  out      out_valid/out_ready, power_on, round_done, out
//           activity_seen, high_grams, low_grams
//
// A tick or an ordinary sample passes the step state, then the hand-off state.
// The sample that closes a round also goes through the shared 47-step
// divider, once for the round maximum and once for the minimum.
// One item is in work at a time; the next is taken while a result waits.
// A stalled output holds the controller in its hand-off state.
// Reset is asynchronous; no clearing pass is needed, cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module load_activity_power_timeout (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lapt_pkg::CIDX_W-1:0]       cfg_index,
    input  wire logic [lapt_pkg::DATA_W-1:0]       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic signed [lapt_pkg::DATA_W-1:0] sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   power_on,
    output logic                                   round_done,
    output logic                                   activity_seen,
    output logic signed [lapt_pkg::DATA_W-1:0]     high_grams,
    output logic signed [lapt_pkg::DATA_W-1:0]     low_grams
);
    import lapt_pkg::*;

    lapt_cmd_t    cmd;
    lapt_status_t status;

    assign cfg_ready = 1'b1;

    lapt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lapt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .sample        (sample),
        .cmd           (cmd),
        .status        (status),
        .power_on      (power_on),
        .round_done    (round_done),
        .activity_seen (activity_seen),
        .high_grams    (high_grams),
        .low_grams     (low_grams)
    );

endmodule : load_activity_power_timeout

`default_nettype wire
